// ===== sv/multi_pin_timestamp_debouncer_assert.svh =====
// Assertion macros shared by the debouncer RTL.
`ifndef MULTI_PIN_TIMESTAMP_DEBOUNCER_ASSERT_SVH
`define MULTI_PIN_TIMESTAMP_DEBOUNCER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MPTD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("debouncer assertion failed");
// Next-cycle implication, checked out of reset.
`define MPTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("debouncer assertion failed");
`else
`define MPTD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MPTD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/mptd_pkg.sv =====
// Package with widths, reset values and register codes of the debouncer.
package mptd_pkg;

    localparam int PIN_COUNT = 16;
    localparam int TIME_BITS = 32;
    localparam int SETTLE_BITS = 16;
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 3;
    localparam int REG_INDEX_BITS = 1;

    localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = SETTLE_BITS'(50);

    typedef logic [PIN_COUNT-1:0] pin_vec_t;
    typedef logic [TIME_BITS-1:0] time_t;

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_SETTLE_TIME = 1'b0
    } reg_index_t;

endpackage

// ===== sv/mptd_channels.sv =====
// Valid/ready channel interfaces for pin samples and debounced results.
interface mptd_sample_if;
    logic                 valid;
    logic                 ready;
    mptd_pkg::pin_vec_t   pin_sample;
    mptd_pkg::time_t      now_ms;

    modport source (output valid, output pin_sample, output now_ms, input ready);
    modport sink (input valid, input pin_sample, input now_ms, output ready);
endinterface

interface mptd_result_if;
    logic                 valid;
    logic                 ready;
    mptd_pkg::pin_vec_t   pressed_mask;

    modport source (output valid, output pressed_mask, input ready);
    modport sink (input valid, input pressed_mask, output ready);
endinterface

// ===== sv/multi_pin_timestamp_debouncer.sv =====
// Per-pin time-stamp debouncer: 16 active-low inputs, one result per sample.
// Path: an accepted request is held in the input register, then moves on into the result register.
// Throughput: one request per cycle while results are taken, limited by the input register to result register step.
// Back-pressure: the input register acts as a skid stage while a result waits.
// Reset (rst_n low, asynchronous): settle time 50 ms, previous sample and stable
// levels all ones (nothing pressed), all change times zero, both stages empty.
`include "multi_pin_timestamp_debouncer_assert.svh"

module multi_pin_timestamp_debouncer
(
    input  logic                                clk,
    input  logic                                rst_n,
    // APB-style configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mptd_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [mptd_pkg::DATA_BITS-1:0]      pwdata,
    output logic [mptd_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready,
    // Sample requests in, debounced results out
    mptd_sample_if.sink                         samples,
    mptd_result_if.source                       results
);

    // ------------------------------------------------------------------
    // Configuration: one register, settle_time_ms, at byte address 0.
    // ------------------------------------------------------------------
    logic [mptd_pkg::SETTLE_BITS-1:0]     settle_reg;
    logic [mptd_pkg::REG_INDEX_BITS-1:0]  reg_index;
    logic                                 cfg_write;
    logic                                 settle_write;
    logic [mptd_pkg::SETTLE_BITS-1:0]     settle_wdata;

    assign pready       = 1'b1;
    assign reg_index    = paddr[mptd_pkg::ADDR_BITS-1:2];
    assign cfg_write    = psel && penable && pwrite && pready;
    assign settle_write = cfg_write && (reg_index == mptd_pkg::REG_SETTLE_TIME);
    assign settle_wdata = pwdata[mptd_pkg::SETTLE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= mptd_pkg::SETTLE_RESET;
        end
        else if (settle_write)
        begin
            settle_reg <= settle_wdata;
        end
    end

    // Read back; addresses past the register list read as zero.
    always_comb
    begin
        unique case (reg_index)
            mptd_pkg::REG_SETTLE_TIME:
                prdata = mptd_pkg::DATA_BITS'(settle_reg);
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register: captures a request whenever it is empty or drains.
    // ------------------------------------------------------------------
    logic                   in_valid_reg;
    mptd_pkg::pin_vec_t     in_sample_reg;
    mptd_pkg::time_t        in_now_reg;
    logic                   out_valid_reg;
    mptd_pkg::pin_vec_t     out_mask_reg;
    logic                   advance;
    logic                   in_accept;

    // Move the held request into the result register when that slot frees up.
    assign advance         = in_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready   = !in_valid_reg || advance;
    assign in_accept       = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_sample_reg <= samples.pin_sample;
            in_now_reg    <= samples.now_ms;
        end
    end

    // ------------------------------------------------------------------
    // Debounce state, updated once per request as it advances.
    // ------------------------------------------------------------------
    mptd_pkg::pin_vec_t     prev_reg;
    mptd_pkg::pin_vec_t     stable_reg;
    mptd_pkg::time_t        change_time_reg [mptd_pkg::PIN_COUNT];

    mptd_pkg::pin_vec_t     changed;
    mptd_pkg::pin_vec_t     stable_next;
    mptd_pkg::time_t        change_time_next [mptd_pkg::PIN_COUNT];
    mptd_pkg::time_t        elapsed [mptd_pkg::PIN_COUNT];
    mptd_pkg::pin_vec_t     flip_on_change;

    assign changed        = in_sample_reg ^ prev_reg;
    assign flip_on_change = (stable_next ^ stable_reg) & changed;

    // Each pin on its own: restart its timer on an edge, and take the new
    // level once the timer has run past the settle time. A pin that just
    // changed sees zero elapsed time, so it keeps its stable level.
    always_comb
    begin
        for (int p = 0; p < mptd_pkg::PIN_COUNT; p++)
        begin
            change_time_next[p] = changed[p] ? in_now_reg : change_time_reg[p];
            elapsed[p]          = in_now_reg - change_time_next[p];
            if (elapsed[p] > mptd_pkg::TIME_BITS'(settle_reg))
            begin
                stable_next[p] = in_sample_reg[p];
            end
            else
            begin
                stable_next[p] = stable_reg[p];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '1;
            stable_reg <= '1;
            for (int p = 0; p < mptd_pkg::PIN_COUNT; p++)
            begin
                change_time_reg[p] <= '0;
            end
        end
        else if (advance)
        begin
            prev_reg   <= in_sample_reg;
            stable_reg <= stable_next;
            for (int p = 0; p < mptd_pkg::PIN_COUNT; p++)
            begin
                change_time_reg[p] <= change_time_next[p];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: hold the inverted stable levels until taken.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_mask_reg <= ~stable_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.pressed_mask = out_mask_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `MPTD_ASSERT_IMPL(a_no_overrun, clk, rst_n, in_accept && in_valid_reg, advance)
    `MPTD_ASSERT_NEXT(a_advance_fills_result, clk, rst_n, advance, out_valid_reg)
    `MPTD_ASSERT_IMPL(a_stable_only_on_quiet_pin, clk, rst_n, advance, flip_on_change == '0)
    `MPTD_ASSERT_NEXT(a_settle_write, clk, rst_n, settle_write, settle_reg == $past(settle_wdata))

endmodule
